>>> sv/wfr_pkg.sv
`default_nettype none

package wfr_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindEmpty   = 2'd1;
  localparam logic [1:0] KindError   = 2'd2;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;

  localparam int unsigned LenW  = 63;
  localparam int unsigned OutDataW = 144;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      raw;
    logic [7:0]      key;
    logic [7:0]      hdr;
    logic            masked;
    logic [LenW-1:0] frame_length;
    logic [LenW-1:0] byte_offset;
    logic            last;
  } wfr_item_t;

endpackage

`default_nettype wire

>>> sv/wfr_front.sv
`default_nettype none

module wfr_front
  import wfr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_fire_i,
  input  wire logic [7:0] in_byte_i,
  output      logic      push_o,
  output      wfr_item_t item_o
);

  typedef enum logic [5:0] {
    PhHdr1    = 6'b000001,
    PhHdr2    = 6'b000010,
    PhExt     = 6'b000100,
    PhKey     = 6'b001000,
    PhPayload = 6'b010000,
    PhError   = 6'b100000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      hdr_q, hdr_d;
  logic            mask_q, mask_d;
  logic [3:0]      ext_left_q, ext_left_d;
  logic            ext_short_q, ext_short_d;
  logic [63:0]     len_q, len_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [31:0]     key_q, key_d;
  logic [1:0]      key_cnt_q, key_cnt_d;

  logic            after_len, start_payload, top_bit, is_last;
  logic [7:0]      key_byte;
  logic [LenW-1:0] pos_inc;

  assign pos_inc = pos_q + LenW'(1);
  assign is_last = (pos_inc == len_q[LenW-1:0]);

  always_comb begin
    case (pos_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    if (!mask_q) begin
      key_byte = 8'd0;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    hdr_d         = hdr_q;
    mask_d        = mask_q;
    ext_left_d    = ext_left_q;
    ext_short_d   = ext_short_q;
    len_d         = len_q;
    pos_d         = pos_q;
    key_d         = key_q;
    key_cnt_d     = key_cnt_q;
    after_len     = 1'b0;
    start_payload = 1'b0;
    top_bit       = 1'b0;
    push_o        = 1'b0;
    item_o        = '0;
    item_o.kind   = KindPayload;

    if (in_fire_i) begin
      unique case (phase_q)
        PhHdr1: begin
          hdr_d   = in_byte_i;
          phase_d = PhHdr2;
        end
        PhHdr2: begin
          mask_d = in_byte_i[7];
          len_d  = '0;
          if (in_byte_i[6:0] == Len16Code) begin
            ext_left_d  = Ext16Bytes;
            ext_short_d = 1'b1;
            phase_d     = PhExt;
          end else if (in_byte_i[6:0] == Len64Code) begin
            ext_left_d  = Ext64Bytes;
            ext_short_d = 1'b0;
            phase_d     = PhExt;
          end else begin
            len_d     = {57'd0, in_byte_i[6:0]};
            after_len = 1'b1;
          end
        end
        PhExt: begin
          len_d = {len_q[55:0], in_byte_i};
          if (ext_left_q != 4'd0) begin
            ext_left_d = ext_left_q - 4'd1;
          end
          if (ext_left_d == 4'd0) begin
            top_bit = ext_short_q ? len_d[15] : len_d[63];
            if (top_bit) begin
              phase_d     = PhError;
              push_o      = 1'b1;
              item_o.kind = KindError;
            end else begin
              after_len = 1'b1;
            end
          end
        end
        PhKey: begin
          key_d     = {key_q[23:0], in_byte_i};
          key_cnt_d = key_cnt_q + 2'd1;
          if (key_cnt_q == 2'd3) begin
            start_payload = 1'b1;
          end
        end
        PhPayload: begin
          push_o             = 1'b1;
          item_o.kind        = KindPayload;
          item_o.raw         = in_byte_i;
          item_o.key         = key_byte;
          item_o.byte_offset = pos_q;
          item_o.last        = is_last;
          pos_d              = pos_inc;
          if (is_last) begin
            phase_d = PhHdr1;
          end
        end
        PhError: begin
          // sticky until reset
        end
        default: begin
        end
      endcase
    end

    if (after_len) begin
      pos_d = '0;
      if (mask_d) begin
        phase_d   = PhKey;
        key_cnt_d = 2'd0;
        key_d     = '0;
      end else begin
        start_payload = 1'b1;
      end
    end

    if (start_payload) begin
      pos_d = '0;
      if (len_d == 64'd0) begin
        phase_d     = PhHdr1;
        push_o      = 1'b1;
        item_o.kind = KindEmpty;
        item_o.last = 1'b1;
      end else begin
        phase_d = PhPayload;
      end
    end

    item_o.hdr          = hdr_d;
    item_o.masked       = mask_d;
    item_o.frame_length = len_d[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdr1;
      hdr_q       <= '0;
      mask_q      <= 1'b0;
      ext_left_q  <= '0;
      ext_short_q <= 1'b0;
      len_q       <= '0;
      pos_q       <= '0;
      key_q       <= '0;
      key_cnt_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      mask_q      <= mask_d;
      ext_left_q  <= ext_left_d;
      ext_short_q <= ext_short_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      key_q       <= key_d;
      key_cnt_q   <= key_cnt_d;
    end
  end

  a_push_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> in_fire_i)
    else $error("front pushed without an input transaction");

  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhError) |-> !push_o)
    else $error("result produced after protocol error");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && item_o.kind == KindError) |=> (phase_q == PhError))
    else $error("error result did not lock the parser");

endmodule

`default_nettype wire

>>> sv/wfr_queue.sv
`default_nettype none

module wfr_queue
  import wfr_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire wfr_item_t item_i,
  output      logic      full_o,
  output      logic      valid_o,
  output      wfr_item_t head_o,
  input  wire logic      pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  wfr_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> sv/wfr_back.sv
`default_nettype none

module wfr_back
  import wfr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire wfr_item_t           q_head_i,
  output      logic                q_pop_o,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output      logic [OutDataW-1:0] m_axis_tdata_o,
  output      logic [1:0]          m_axis_tuser_o,
  output      logic                m_axis_tlast_o
);

  logic            out_valid_q;
  logic [1:0]      kind_q;
  logic [7:0]      data_q;
  logic [7:0]      hdr_q;
  logic            masked_q;
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] off_q;
  logic            last_q;

  assign q_pop_o = q_valid_i && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q   <= q_head_i.kind;
      data_q   <= q_head_i.raw ^ q_head_i.key;
      hdr_q    <= q_head_i.hdr;
      masked_q <= q_head_i.masked;
      len_q    <= q_head_i.frame_length;
      off_q    <= q_head_i.byte_offset;
      last_q   <= q_head_i.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {1'b0, off_q, len_q, masked_q, hdr_q[3:0], hdr_q[6:4],
                            hdr_q[7], data_q};

endmodule

`default_nettype wire

>>> sv/websocket_frame_receiver_top.sv
// Results cross the queue, then the output register. Throughput: one byte per cycle
// unless the queue is full; the front parser resolves each byte combinationally,
// its longest path being the 63-bit offset increment and end-of-frame compare.
// A two-entry queue and the output register let input and output stall independently.
// Reset (rst_ni low, asynchronous): parser expects a first header byte, queue and
// output are empty. After a length error all input is dropped until the next reset.
`default_nettype none

module websocket_frame_receiver_top
  import wfr_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,  // [7:0] in_byte
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [7:0] data_byte, [8] fin_flag, [11:9] rsv_bits, [15:12] op_code, [16] masked,
  // [79:17] frame_length, [142:80] byte_offset, [143] zero
  output      logic [OutDataW-1:0] m_axis_tdata_o,
  output      logic [1:0]          m_axis_tuser_o,  // [1:0] kind
  output      logic                m_axis_tlast_o
);

  logic      in_fire, push, q_full, q_valid, q_pop;
  wfr_item_t item, head;

  assign s_axis_tready_o = !q_full;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  wfr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_byte_i (s_axis_tdata_i),
    .push_o    (push),
    .item_o    (item)
  );

  wfr_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (q_pop)
  );

  wfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (head),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

>>> tb/websocket_frame_receiver_top_tb.sv
`timescale 1ns / 1ps

module websocket_frame_receiver_top_tb;
  import wfr_pkg::*;

  typedef enum logic [2:0] {
    StHdr1, StHdr2, StExtLen, StMaskKey, StPayload, StError
  } rx_state_e;

  typedef enum int {Len7, Len16, Len64} len_form_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      data;
    logic            fin;
    logic [2:0]      rsv;
    logic [3:0]      op;
    logic            masked;
    logic [LenW-1:0] flen;
    logic [LenW-1:0] offs;
    logic            last;
  } ws_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  websocket_frame_receiver_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // parser mirror
  rx_state_e       rx_state   = StHdr1;
  logic [7:0]      hdr_q      = '0;
  logic            key_on     = 1'b0;
  logic [3:0]      ext_left   = '0;
  logic            ext_short  = 1'b0;
  logic [63:0]     len_acc    = '0;
  logic [LenW-1:0] data_pos   = '0;
  logic [31:0]     key_word   = '0;
  logic [1:0]      key_cnt    = '0;

  ws_result_t  pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_sent   = 0;
  int unsigned hold_cycles  = 0;
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic ws_result_t frame_result(logic [1:0] kind, logic [7:0] data,
                                              logic [LenW-1:0] offs, logic last);
    ws_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.fin    = hdr_q[7];
    r.rsv    = hdr_q[6:4];
    r.op     = hdr_q[3:0];
    r.masked = key_on;
    r.flen   = len_acc[LenW-1:0];
    r.offs   = offs;
    r.last   = last;
    return r;
  endfunction

  task automatic begin_data();
    data_pos = '0;
    if (len_acc == 64'd0) begin
      rx_state = StHdr1;
      pending_results.push_back(frame_result(KindEmpty, 8'h00, '0, 1'b1));
    end else begin
      rx_state = StPayload;
    end
  endtask

  task automatic length_known();
    data_pos = '0;
    if (key_on) begin
      rx_state = StMaskKey;
      key_cnt  = '0;
      key_word = '0;
    end else begin
      begin_data();
    end
  endtask

  task automatic decode_rx_byte(input logic [7:0] b);
    logic [31:0] shifted;
    logic        at_end;
    case (rx_state)
      StHdr1: begin
        hdr_q    = b;
        rx_state = StHdr2;
      end
      StHdr2: begin
        key_on  = b[7];
        len_acc = '0;
        if (b[6:0] == Len16Code) begin
          ext_left  = Ext16Bytes;
          ext_short = 1'b1;
          rx_state  = StExtLen;
        end else if (b[6:0] == Len64Code) begin
          ext_left  = Ext64Bytes;
          ext_short = 1'b0;
          rx_state  = StExtLen;
        end else begin
          len_acc = {57'd0, b[6:0]};
          length_known();
        end
      end
      StExtLen: begin
        len_acc = {len_acc[55:0], b};
        if (ext_left != 0) ext_left = ext_left - 4'd1;
        if (ext_left == 0) begin
          // top bit of either extended form is a protocol error, sticky until reset
          if (ext_short ? len_acc[15] : len_acc[63]) begin
            rx_state = StError;
            pending_results.push_back(frame_result(KindError, 8'h00, '0, 1'b0));
          end else begin
            length_known();
          end
        end
      end
      StMaskKey: begin
        key_word = {key_word[23:0], b};
        key_cnt  = key_cnt + 2'd1;
        if (key_cnt == 2'd0) begin_data();
      end
      StPayload: begin
        // first key byte received sits in the top byte
        shifted = key_on ? key_word >> (5'd24 - {data_pos[1:0], 3'b000}) : 32'd0;
        at_end  = (data_pos + 63'd1) == len_acc[LenW-1:0];
        pending_results.push_back(frame_result(KindPayload, b ^ shifted[7:0], data_pos,
                                               at_end));
        data_pos = data_pos + 63'd1;
        if (at_end) rx_state = StHdr1;
      end
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame_head(input logic [7:0] hdr, input logic mask,
                                 input len_form_e form, input logic [63:0] len,
                                 input logic [31:0] key);
    send_byte(hdr);
    case (form)
      Len7: send_byte({mask, len[6:0]});
      Len16: begin
        send_byte({mask, Len16Code});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask, Len64Code});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (mask) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic mask, input len_form_e form,
                            input logic [63:0] len, input logic [31:0] key);
    send_frame_head(hdr, mask, form, len, key);
    for (longint unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // drop valid, then hold until every expected transaction has come out
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_frames();
    send_frame_head(8'h81, 1'b0, Len7, 64'd0, 32'd0);
    // masked zero length: result lands on the last key byte
    send_frame_head(8'h0a, 1'b1, Len7, 64'd0, 32'hffff_ffff);
    wait_drained();
  endtask

  task automatic test_short_frames();
    send_frame_head(8'hff, 1'b0, Len7, 64'd2, 32'd0);
    send_byte(8'h00);
    send_byte(8'hff);
    // five bytes so the key index wraps back to the first key byte
    send_frame_head(8'h00, 1'b1, Len7, 64'd5, 32'h5a_c3_0f_e1);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h96);
    // non-minimal 16-bit length
    send_frame_head(8'h82, 1'b0, Len16, 64'd1, 32'd0);
    send_byte(8'h7e);
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_cycles  = 200;
    send_frame(8'h82, 1'b1, Len16, 64'd150, $urandom);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    len_form_e   form;
    start        = bytes_sent;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    while (bytes_sent - start < 1580) begin
      if (bytes_sent - start > 1300) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      pick = $urandom_range(0, 19);
      if (pick < 13) len = $urandom_range(0, 12);
      else if (pick < 19) len = $urandom_range(13, 125);
      else len = $urandom_range(126, 300);
      pick = $urandom_range(0, 9);
      if (len > 125) begin
        if (pick < 7) form = Len16;
        else form = Len64;
      end else if (pick < 6) begin
        form = Len7;
      end else if (pick < 9) begin
        form = Len16;
      end else begin
        form = Len64;
      end
      send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, 64'(len),
                 $urandom);
    end
    wait_drained();
  endtask

  // error is sticky, so this runs last; the trailing bytes must vanish
  task automatic test_length_error();
    logic [63:0] bad_len;
    bad_len = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 1) begin
      bad_len[15] = 1'b1;
      send_frame_head(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), Len16, bad_len,
                      $urandom);
    end else begin
      bad_len[63] = 1'b1;
      send_frame_head(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), Len64, bad_len,
                      $urandom);
    end
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  task automatic report_mismatch(input string what, input ws_result_t want,
                                 input ws_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t %s: exp kind=%0d data=%02h fin=%0d rsv=%0d op=%0h m=%0d len=%0d off=%0d last=%0d",
               $realtime, what, want.kind, want.data, want.fin, want.rsv, want.op,
               want.masked, want.flen, want.offs, want.last);
      $display("%0t %s: got kind=%0d data=%02h fin=%0d rsv=%0d op=%0h m=%0d len=%0d off=%0d last=%0d",
               $realtime, what, got.kind, got.data, got.fin, got.rsv, got.op,
               got.masked, got.flen, got.offs, got.last);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    ws_result_t got;
    ws_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind   = m_axis_tuser_o;
      got.data   = m_axis_tdata_o[7:0];
      got.fin    = m_axis_tdata_o[8];
      got.rsv    = m_axis_tdata_o[11:9];
      got.op     = m_axis_tdata_o[15:12];
      got.masked = m_axis_tdata_o[16];
      got.flen   = m_axis_tdata_o[79:17];
      got.offs   = m_axis_tdata_o[142:80];
      got.last   = m_axis_tlast_o;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.data !== want.data || got.fin !== want.fin ||
            got.rsv !== want.rsv || got.op !== want.op || got.masked !== want.masked ||
            got.flen !== want.flen || got.offs !== want.offs || got.last !== want.last ||
            m_axis_tdata_o[OutDataW-1] !== 1'b0) begin
          report_mismatch("field mismatch", want, got);
        end
      end
    end
  end

  initial begin : sink_ready
    int unsigned n;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready_i <= 1'b0;
        hold_cycles--;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        m_axis_tready_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("websocket_frame_receiver_top_tb: done, errors");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_frames();
    test_short_frames();
    test_backpressure();
    test_random_frames();
    test_length_error();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("websocket_frame_receiver_top_tb: done, clean");
    end else begin
      $display("websocket_frame_receiver_top_tb: done, errors");
    end
    $finish;
  end

endmodule
